// ===== src/led_pattern_generator_top_defines.svh =====
// Assertion macros shared by the LED pattern generator RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef LED_PATTERN_GENERATOR_TOP_DEFINES_SVH
`define LED_PATTERN_GENERATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpg assertion failed");

`else

`define LPG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/lpg_pkg.sv =====
package lpg_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int PHASE_CNT_W = 16;
    localparam int TEMP_CNT_W  = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    // Phases per cycle of the two flashing patterns.
    localparam logic [2:0] FLASH_PHASES     = 3'd2;
    localparam logic [2:0] FLASH_ALT_PHASES = 3'd3;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_RSVD  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PAT_BLINK      = 3'd0,
        PAT_STEADY_ON  = 3'd1,
        PAT_STEADY_OFF = 3'd2,
        PAT_TIMED      = 3'd3,
        PAT_ALT_BLINK  = 3'd4
    } t_pattern;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL = 2'd0,
        CFG_SECOND_PIN   = 2'd1,
        CFG_FLASH_TICKS  = 2'd2,
        CFG_TEMP_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                   active_level;
        logic                   second_pin_present;
        logic [PHASE_CNT_W-1:0] flash_ticks;
        logic [TEMP_CNT_W-1:0]  temp_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic [2:0] pattern;
        logic       led_enable;
        logic       switch_on;
    } t_item;

    typedef struct packed {
        logic temp_expired;
        logic pin1_level;
        logic pin0_level;
    } t_result;

endpackage

// ===== src/led_pattern_generator_top.sv =====
// Channel   Direction  Ports                      Contents
// s_axis    in         i_s_tvalid/o_s_tready      tuser: mode; tdata: pattern, enable, switch
// m_axis    out        o_m_tvalid/i_m_tready      tdata: pin0, pin1, temp_expired
// cfg       in         i_cfg_valid/o_cfg_ready    index 0..3, 32-bit write data
//
// One input beat per clock is sustained while m_axis is not stalled; each beat yields exactly one
// result beat, through the input register, then pattern logic into the result register.
// Synchronous active-low reset sets the config registers to their defaults and clears pattern state and both valids.
// Backpressure on m_axis stalls the core; s_axis keeps taking one more beat into the
// input register while a finished result waits.
// Config registers are always ready and take effect on the next beat.
module led_pattern_generator_top
    import lpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [1:0]            i_s_tuser,   // [1:0] mode
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [2:0] pattern, [3] led_enable, [4] switch_on

    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [0] pin0_level, [1] pin1_level, [2] temp_expired

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    w_cfg;
    t_item   w_s_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_step;
    t_result w_result;

    // Unpack the slave beat into the item fields.
    assign w_s_item.mode       = t_mode'(i_s_tuser);
    assign w_s_item.pattern    = i_s_tdata[2:0];
    assign w_s_item.led_enable = i_s_tdata[3];
    assign w_s_item.switch_on  = i_s_tdata[4];

    // Advance the core whenever an item is held and the result register is free
    // or being drained this cycle.
    assign w_step = w_item_valid && (!o_m_tvalid || i_m_tready);

    lpg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lpg_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (w_s_item),
        .i_advance (w_step),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    lpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    lpg_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_result (w_result),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata)
    );

endmodule

// ===== src/lpg_cfg_regs.sv =====
module lpg_cfg_regs
    import lpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE_LEVEL: n_cfg.active_level       = i_cfg_data[0];
                CFG_SECOND_PIN:   n_cfg.second_pin_present = i_cfg_data[0];
                CFG_FLASH_TICKS:  n_cfg.flash_ticks        = i_cfg_data[PHASE_CNT_W-1:0];
                CFG_TEMP_TIMEOUT: n_cfg.temp_timeout_ticks = i_cfg_data[TEMP_CNT_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level       <= 1'b1;
            r_cfg.second_pin_present <= 1'b0;
            r_cfg.flash_ticks        <= PHASE_CNT_W'(1);
            r_cfg.temp_timeout_ticks <= TEMP_CNT_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/lpg_in_stage.sv =====
`include "led_pattern_generator_top_defines.svh"

module lpg_in_stage
    import lpg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // Take a new beat when the register is empty or drains this cycle.
    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    `LPG_ASSERT_IMP(a_adv_needs_item, i_clk, i_rst_n, i_advance, r_valid)
    `LPG_ASSERT_NEXT(a_held_item_stays, i_clk, i_rst_n, r_valid && !i_advance, r_valid && (r_item == $past(r_item)))

endmodule

// ===== src/lpg_core.sv =====
`include "led_pattern_generator_top_defines.svh"

module lpg_core
    import lpg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [2:0]             r_held_pattern;
    logic                   r_held_enable;
    logic [1:0]             r_phase_index;
    logic [PHASE_CNT_W-1:0] r_phase_count;
    logic [TEMP_CNT_W-1:0]  r_temp_count;
    logic [1:0]             r_lit;

    logic [2:0]             n_held_pattern;
    logic                   n_held_enable;
    logic [1:0]             n_phase_index;
    logic [PHASE_CNT_W-1:0] n_phase_count;
    logic [TEMP_CNT_W-1:0]  n_temp_count;
    logic [1:0]             n_lit;

    logic                   w_load;
    logic                   w_tick;
    logic                   w_dark;
    logic [1:0]             w_pi;
    logic [PHASE_CNT_W-1:0] w_pc;
    logic [TEMP_CNT_W-1:0]  w_tc;
    logic [PHASE_CNT_W-1:0] w_pc_inc;
    logic [2:0]             w_pi_inc;
    logic                   w_phase_wrap;
    logic [2:0]             w_nphases;
    logic [1:0]             w_pi_adv;
    logic [TEMP_CNT_W-1:0]  w_tc_inc;
    logic                   w_expired;

    assign w_load = (i_item.mode == MODE_LOAD);
    assign w_tick = (i_item.mode == MODE_TICK);
    assign w_dark = (i_item.mode == MODE_CLEAR) || (i_item.mode == MODE_RSVD)
                    || !i_item.switch_on;

    // A load restarts the timers before the pattern is evaluated.
    assign w_pi = w_load ? 2'd0 : r_phase_index;
    assign w_pc = w_load ? '0 : r_phase_count;
    assign w_tc = w_load ? '0 : r_temp_count;

    assign w_nphases    = (n_held_pattern == PAT_ALT_BLINK) ? FLASH_ALT_PHASES : FLASH_PHASES;
    assign w_pc_inc     = w_pc + PHASE_CNT_W'(1);
    assign w_phase_wrap = (w_pc_inc >= i_cfg.flash_ticks);
    assign w_pi_inc     = {1'b0, w_pi} + 3'd1;
    assign w_pi_adv     = (w_pi_inc >= w_nphases) ? 2'd0 : w_pi_inc[1:0];
    assign w_tc_inc     = w_tc + TEMP_CNT_W'(1);

    always_comb begin
        n_held_pattern = w_load ? i_item.pattern : r_held_pattern;
        n_held_enable  = w_load ? i_item.led_enable : r_held_enable;
        n_phase_index  = w_pi;
        n_phase_count  = w_pc;
        n_temp_count   = w_tc;
        n_lit          = r_lit;
        w_expired      = 1'b0;

        if (w_dark) begin
            n_lit         = 2'b00;
            n_phase_index = 2'd0;
            n_phase_count = '0;
            n_temp_count  = '0;
        end else if (n_held_enable) begin
            case (t_pattern'(n_held_pattern))
                PAT_BLINK, PAT_ALT_BLINK: begin
                    if (w_tick) begin
                        n_phase_count = w_phase_wrap ? '0 : w_pc_inc;
                        n_phase_index = w_phase_wrap ? w_pi_adv : w_pi;
                    end
                    if (n_held_pattern == PAT_BLINK) begin
                        n_lit = (n_phase_index == 2'd0) ? 2'b11 : 2'b00;
                    end else begin
                        n_lit = (n_phase_index == 2'd0) ? 2'b01 :
                                (n_phase_index == 2'd1) ? 2'b10 : 2'b00;
                    end
                end
                PAT_STEADY_ON: begin
                    n_lit = 2'b11;
                end
                PAT_STEADY_OFF: begin
                    n_lit = 2'b00;
                end
                PAT_TIMED: begin
                    n_lit = 2'b11;
                    if (w_tick) begin
                        n_temp_count = w_tc_inc;
                        if (w_tc_inc >= i_cfg.temp_timeout_ticks) begin
                            w_expired     = 1'b1;
                            n_held_enable = 1'b0;
                            n_temp_count  = '0;
                        end
                    end
                end
                default: begin
                    // Unknown pattern code: pins and timers hold.
                end
            endcase
        end
    end

    always_comb begin
        o_result.pin0_level   = n_lit[0] ? i_cfg.active_level : !i_cfg.active_level;
        o_result.pin1_level   = (i_cfg.second_pin_present && n_lit[1]) ?
                                i_cfg.active_level : !i_cfg.active_level;
        o_result.temp_expired = w_expired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pattern <= PAT_BLINK;
            r_held_enable  <= 1'b0;
            r_phase_index  <= 2'd0;
            r_phase_count  <= '0;
            r_temp_count   <= '0;
            r_lit          <= 2'b00;
        end else if (i_step) begin
            r_held_pattern <= n_held_pattern;
            r_held_enable  <= n_held_enable;
            r_phase_index  <= n_phase_index;
            r_phase_count  <= n_phase_count;
            r_temp_count   <= n_temp_count;
            r_lit          <= n_lit;
        end
    end

    `LPG_ASSERT_NEXT(a_expire_disables, i_clk, i_rst_n, i_step && w_expired, !r_held_enable && (r_temp_count == '0))
    `LPG_ASSERT_IMP(a_phase_in_range, i_clk, i_rst_n, 1'b1, r_phase_index < FLASH_ALT_PHASES[1:0])
    `LPG_ASSERT_NEXT(a_dark_clears, i_clk, i_rst_n, i_step && w_dark, (r_lit == 2'b00) && (r_phase_count == '0))

endmodule

// ===== src/lpg_out_stage.sv =====
`include "led_pattern_generator_top_defines.svh"

module lpg_out_stage
    import lpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_result              i_result,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [M_TDATA_W-1:0] o_tdata
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_tvalid = r_valid;
    assign o_tdata  = M_TDATA_W'(r_result);

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    `LPG_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_load && r_valid, i_tready)

endmodule

// ===== tb/tb_led_pattern_generator_top.sv =====
`timescale 1ns / 100ps

module tb_led_pattern_generator_top;
    import lpg_pkg::*;

    // Pattern codes outside the defined set; a load of one leaves the pins alone.
    localparam logic [2:0] PAT_UNDEF_LO = 3'd5;
    localparam logic [2:0] PAT_UNDEF_HI = 3'd7;

    localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int TAIL_CYCLES  = 8;     // settle time after the last result
    localparam int NUM_PHASES   = 8;

    // Predicts the pin levels for every accepted item and checks result beats
    // against them in order.
    class led_pins_scoreboard;
        // Register copies.
        logic        active_level;
        logic        second_pin;
        logic [15:0] flash_ticks;
        logic [31:0] temp_timeout;
        // Pattern state.
        logic [2:0]  held_pattern;
        logic        held_enable;
        logic [1:0]  phase_index;
        logic [15:0] phase_count;
        logic [31:0] temp_count;
        logic [1:0]  lit;       // bit0 pin0 lit, bit1 pin1 lit
        t_result     expected_pins_q[$];
        int          errors;

        function new();
            active_level = 1'b1;
            second_pin   = 1'b0;
            flash_ticks  = 16'd1;
            temp_timeout = 32'd1;
            held_pattern = PAT_BLINK;
            held_enable  = 1'b0;
            restart_timers();
            lit          = 2'b00;
            errors       = 0;
        endfunction

        task report(string what);
            $display("tb: mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void restart_timers();
            phase_index = 2'd0;
            phase_count = 16'd0;
            temp_count  = 32'd0;
        endfunction

        // Advance one tick through a flashing pattern of nphases phases.
        function void step_phase(logic [2:0] nphases);
            phase_count = phase_count + 16'd1;
            if (phase_count >= flash_ticks) begin
                phase_count = 16'd0;
                phase_index = ({1'b0, phase_index} + 3'd1 >= nphases) ? 2'd0
                                                                      : phase_index + 2'd1;
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_ACTIVE_LEVEL: active_level = val[0];
                CFG_SECOND_PIN:   second_pin   = val[0];
                CFG_FLASH_TICKS:  flash_ticks  = val[15:0];
                CFG_TEMP_TIMEOUT: temp_timeout = val;
                default: ;
            endcase
        endfunction

        // Work out the pins that one accepted item produces and queue them.
        function void note_beat(t_mode mode, logic [2:0] pat, logic en, logic sw);
            logic    tick;
            logic    expired;
            t_result pins;
            tick    = (mode == MODE_TICK);
            expired = 1'b0;
            if (mode == MODE_LOAD) begin
                held_pattern = pat;
                held_enable  = en;
                restart_timers();
            end
            if (mode == MODE_CLEAR || mode == MODE_RSVD || !sw) begin
                lit = 2'b00;
                restart_timers();
            end else if (held_enable) begin
                case (held_pattern)
                    PAT_BLINK: begin
                        if (tick) step_phase(FLASH_PHASES);
                        lit = (phase_index == 2'd0) ? 2'b11 : 2'b00;
                    end
                    PAT_STEADY_ON:  lit = 2'b11;
                    PAT_STEADY_OFF: lit = 2'b00;
                    PAT_TIMED: begin
                        lit = 2'b11;
                        if (tick) begin
                            temp_count = temp_count + 32'd1;
                            if (temp_count >= temp_timeout) begin
                                expired     = 1'b1;
                                held_enable = 1'b0;
                                temp_count  = 32'd0;
                            end
                        end
                    end
                    PAT_ALT_BLINK: begin
                        if (tick) step_phase(FLASH_ALT_PHASES);
                        lit = (phase_index == 2'd0) ? 2'b01 :
                              (phase_index == 2'd1) ? 2'b10 : 2'b00;
                    end
                    default: ;
                endcase
            end
            pins.pin0_level   = lit[0] ? active_level : ~active_level;
            pins.pin1_level   = (second_pin && lit[1]) ? active_level : ~active_level;
            pins.temp_expired = expired;
            expected_pins_q.push_back(pins);
        endfunction

        task check_beat(logic [M_TDATA_W-1:0] data);
            t_result want;
            if (expected_pins_q.size() == 0) begin
                report($sformatf("result beat 0x%02h with nothing expected", data));
                return;
            end
            want = expected_pins_q.pop_front();
            if (data[0] !== want.pin0_level)
                report($sformatf("pin0_level got %b want %b", data[0], want.pin0_level));
            if (data[1] !== want.pin1_level)
                report($sformatf("pin1_level got %b want %b", data[1], want.pin1_level));
            if (data[2] !== want.temp_expired)
                report($sformatf("temp_expired got %b want %b", data[2], want.temp_expired));
            if (data[M_TDATA_W-1:3] !== '0)
                report($sformatf("tdata padding got 0x%02h want 0", data[M_TDATA_W-1:3]));
        endtask

        function int pending();
            return expected_pins_q.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [1:0]            i_s_tuser   = '0;   // [1:0] mode
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;   // [2:0] pattern, [3] led_enable, [4] switch_on
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;          // [0] pin0_level, [1] pin1_level, [2] temp_expired
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    led_pins_scoreboard pins_sb;
    bit src_fast = 1'b0;     // sender sends back to back
    bit snk_fast = 1'b0;     // receiver never stalls
    int idle_cycles = 0;

    led_pattern_generator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: end the run once no beat of any channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: draw a stall per beat, then hold ready until a beat lands.
    // Signals read right after the edge still carry their pre-edge values.
    initial begin : result_sink
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = snk_fast ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            pins_sb.check_beat(o_m_tdata);
        end
    end

    // Present one item and hold it until accepted. Valid stays high afterwards
    // so a zero gap runs straight into the next beat; a gap drops it first.
    task automatic send_item(input t_mode mode, input logic [2:0] pat, input logic en,
                             input logic sw);
        int unsigned gap;
        gap = src_fast ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {3'b000, sw, en, pat};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pins_sb.note_beat(mode, pat, en, sw);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pins_sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pins_sb.set_reg(idx, val);
    endtask

    // Write all four registers while the block is idle.
    task automatic apply_settings(input logic [31:0] act, input logic [31:0] two,
                                  input logic [31:0] flash, input logic [31:0] timeout);
        drain_results();
        write_reg(CFG_ACTIVE_LEVEL, act);
        write_reg(CFG_SECOND_PIN, two);
        write_reg(CFG_FLASH_TICKS, flash);
        write_reg(CFG_TEMP_TIMEOUT, timeout);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ticks and well-formed loads with the switch on, so the patterns
    // run deep; the rest clears, reserved modes, switch-off and odd loads.
    task automatic send_random_item();
        int unsigned roll;
        t_mode       mode;
        logic [2:0]  pat;
        logic        en;
        logic        sw;
        roll = $urandom_range(0, 99);
        mode = MODE_TICK;
        pat  = 3'($urandom_range(0, 4));
        en   = 1'b1;
        sw   = 1'b1;
        if (roll < 60) begin
            // pattern and enable are ignored on a tick; toggle them anyway
            pat = 3'($urandom);
            en  = 1'($urandom);
        end else if (roll < 80) begin
            mode = MODE_LOAD;
            en   = ($urandom_range(0, 9) != 0);
        end else if (roll < 86) begin
            mode = MODE_CLEAR;
        end else if (roll < 89) begin
            mode = MODE_RSVD;
        end else if (roll < 94) begin
            mode = t_mode'($urandom_range(0, 3));
            sw   = 1'b0;
        end else begin
            mode = MODE_LOAD;
            pat  = 3'($urandom);
            en   = 1'($urandom);
        end
        send_item(mode, pat, en, sw);
    endtask

    initial begin : stimulus
        int n_items;
        pins_sb = new();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every pattern, expiry, undefined codes, reserved mode,
        // switch off during tick and load, disabled load, clear.
        apply_settings(32'd1, 32'd1, 32'd2, 32'd3);
        send_item(MODE_LOAD, PAT_BLINK, 1'b1, 1'b1);
        repeat (3) send_item(MODE_TICK, PAT_BLINK, 1'b0, 1'b1);
        send_item(MODE_LOAD, PAT_STEADY_ON, 1'b1, 1'b1);
        send_item(MODE_LOAD, PAT_STEADY_OFF, 1'b1, 1'b1);
        send_item(MODE_LOAD, PAT_TIMED, 1'b1, 1'b1);
        repeat (4) send_item(MODE_TICK, PAT_BLINK, 1'b0, 1'b1);  // expire, then hold
        send_item(MODE_LOAD, PAT_ALT_BLINK, 1'b1, 1'b1);
        repeat (4) send_item(MODE_TICK, PAT_BLINK, 1'b1, 1'b1);
        send_item(MODE_LOAD, PAT_UNDEF_LO, 1'b1, 1'b1);
        send_item(MODE_TICK, PAT_BLINK, 1'b0, 1'b1);
        send_item(MODE_LOAD, PAT_UNDEF_HI, 1'b0, 1'b1);
        send_item(MODE_RSVD, PAT_ALT_BLINK, 1'b1, 1'b1);
        send_item(MODE_LOAD, PAT_STEADY_ON, 1'b1, 1'b1);
        send_item(MODE_TICK, PAT_BLINK, 1'b0, 1'b0);
        send_item(MODE_LOAD, PAT_STEADY_ON, 1'b1, 1'b0);
        send_item(MODE_LOAD, PAT_STEADY_ON, 1'b0, 1'b1);
        send_item(MODE_CLEAR, PAT_UNDEF_HI, 1'b1, 1'b1);

        // Random phases, each under its own register setting and idling style.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            n_items = 280;
            case (ph)
                0: apply_settings(32'd0, 32'd1, 32'd1, 32'd1);
                1: apply_settings(32'd1, 32'd1, 32'd3, 32'd4);
                2: apply_settings(32'd0, 32'd0, 32'd2, 32'd6);
                3: apply_settings(32'd1, 32'd1, 32'd0, 32'd0);   // zero counts act as one
                4: begin
                    apply_settings(32'd0, 32'd1, 32'hFFFF, 32'hFFFF_FFFF);
                    n_items = 60;
                end
                5: apply_settings(32'd1, 32'd1, $urandom_range(1, 5), $urandom_range(1, 12));
                6: begin
                    // full-width random data, upper bits of the narrow registers too
                    apply_settings($urandom, $urandom, $urandom, $urandom);
                    n_items = 60;
                end
                default: apply_settings(32'd1, 32'd1, 32'd1, 32'd2);
            endcase
            src_fast = (ph % 3 == 1) || (ph == NUM_PHASES - 1);
            snk_fast = (ph % 3 == 2) || (ph == NUM_PHASES - 1);
            for (int k = 0; k < n_items; k++) begin
                // hold off mid-phase until the pipeline is empty
                if (k == n_items / 2) drain_results();
                send_random_item();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pins_sb.pending() != 0)
            pins_sb.report($sformatf("%0d results never arrived", pins_sb.pending()));
        if (pins_sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
